// ===== rtl/core/pdbq_pkg.sv =====
// Shared types and constants for the priority-drop batch queue.
package pdbq_pkg;

   // Fixed field widths of the request and response beats
   localparam int unsigned OpW       = 2;
   localparam int unsigned PayW      = 32;
   localparam int unsigned AmountW   = 6;
   localparam int unsigned CapW      = 6;
   localparam int unsigned KindW     = 2;
   localparam int unsigned StatusW   = 2;
   localparam int unsigned OccW      = 6;

   // Parameter defaults and limits
   localparam int unsigned DefQueueDepth  = 32;
   localparam int unsigned DefPayloadBits = 32;
   localparam int unsigned MaxResults     = 32;
   localparam logic [CapW-1:0] CapReset   = 6'd32;

   // Request opcodes
   typedef enum logic [OpW-1:0] {
      OP_ENQUEUE = 2'd0,
      OP_PEEK    = 2'd1,
      OP_REMOVE  = 2'd2,
      OP_COUNT   = 2'd3
   } op_type;

   // Response kinds
   typedef enum logic [KindW-1:0] {
      KIND_ENQ_STATUS = 2'd0,
      KIND_PEEK       = 2'd1,
      KIND_REMOVE_ACK = 2'd2,
      KIND_COUNT      = 2'd3
   } kind_type;

   // Enqueue status codes
   typedef enum logic [StatusW-1:0] {
      ST_ACCEPTED = 2'd0,
      ST_DROPPED  = 2'd1,
      ST_REJECTED = 2'd2
   } status_type;

endpackage

// ===== rtl/core/priority_drop_batch_queue_core.sv =====
// Top level of the priority-drop batch queue: circular record memory and its sequencer.
//
//  channel | ports                         | handshake       | beat
//  --------+-------------------------------+-----------------+-------------------------------
//  request | req_valid / req_stall         | valid and stall | opcode, payload, critical, amount
//  result  | rsp_valid / rsp_stall         | valid and stall | kind, status, record, occupancy, last
//  config  | csr_valid / csr_ready         | valid and ready | capacity_limit
//
// Count, remove and enqueue with room go from idle straight to the done state. An
// enqueue into a full queue scans one critical flag per cycle and then shifts the
// records ahead of the dropped one up by one per cycle, or is rejected when every
// record is critical. A peek returns one record per cycle while the result channel
// is not stalled; the single memory read port sets the pace of scan, shift and peek.
// Reset is synchronous and needs no clearing pass.
// A stalled result holds in the output register; the sequencer waits on it.
module priority_drop_batch_queue_core #(
   parameter int unsigned QUEUE_DEPTH  = pdbq_pkg::DefQueueDepth,
   parameter int unsigned PAYLOAD_BITS = pdbq_pkg::DefPayloadBits
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [pdbq_pkg::OpW-1:0]     req_opcode,
   input  logic [pdbq_pkg::PayW-1:0]    req_record_payload,
   input  logic                         req_record_critical,
   input  logic [pdbq_pkg::AmountW-1:0] req_amount,
   // result channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pdbq_pkg::KindW-1:0]   rsp_result_kind,
   output logic [pdbq_pkg::StatusW-1:0] rsp_enqueue_status,
   output logic [pdbq_pkg::PayW-1:0]    rsp_out_payload,
   output logic                         rsp_out_critical,
   output logic                         rsp_out_valid,
   output logic [pdbq_pkg::OccW-1:0]    rsp_occupancy,
   output logic                         rsp_last,
   // configuration channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [pdbq_pkg::CapW-1:0]    csr_capacity_limit
);
   import pdbq_pkg::*;

   localparam int unsigned AddrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CntW  = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned CmpW  = (CntW > CapW) ? CntW : CapW;
   localparam int unsigned WideW = (PAYLOAD_BITS > PayW) ? PAYLOAD_BITS : PayW;

   typedef struct packed {
      logic                    crit;
      logic [PAYLOAD_BITS-1:0] pay;
   } entry_type;

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_SCAN   = 6'b000010,
      S_SHIFT  = 6'b000100,
      S_APPEND = 6'b001000,
      S_PEEK   = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   // head + offset, wrapped into the memory; the sum stays below twice the depth
   function automatic logic [AddrW-1:0] wrap_add(input logic [AddrW-1:0] base,
                                                 input logic [CntW-1:0]  off);
      logic [AddrW:0] sum;
      sum = {1'b0, base} + (AddrW+1)'(off);
      if (sum >= (AddrW+1)'(QUEUE_DEPTH)) begin
         sum = sum - (AddrW+1)'(QUEUE_DEPTH);
      end
      return sum[AddrW-1:0];
   endfunction

   // Control and result registers
   state_type         state_ff, state_in;
   logic [AddrW-1:0]  head_ff, head_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic [CntW-1:0]   pos_ff, pos_in;
   logic [CntW-1:0]   take_ff, take_in;
   logic [CapW-1:0]   cap_ff, cap_in;
   entry_type         new_entry_ff, new_entry_in;
   kind_type          res_kind_ff, res_kind_in;
   status_type        res_status_ff, res_status_in;

   logic              rsp_valid_ff, rsp_valid_in;
   kind_type          rsp_kind_ff, rsp_kind_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [PayW-1:0]   rsp_payload_ff, rsp_payload_in;
   logic              rsp_crit_ff, rsp_crit_in;
   logic              rsp_outv_ff, rsp_outv_in;
   logic [OccW-1:0]   rsp_occ_ff, rsp_occ_in;
   logic              rsp_last_ff, rsp_last_in;

   // Record memory
   entry_type         mem [QUEUE_DEPTH];
   entry_type         rd_data_ff;
   logic              mem_rd_en;
   logic              mem_wr_en;
   logic [CntW-1:0]   rd_pos;
   logic [CntW-1:0]   wr_pos;
   entry_type         mem_wr_data;
   logic [AddrW-1:0]  rd_addr;
   logic [AddrW-1:0]  wr_addr;

   // Misc combinational
   logic              accept;
   logic              out_free;
   logic [CmpW-1:0]   cap_eff;
   logic [CmpW-1:0]   count_cmp;
   logic [CmpW-1:0]   amount_cmp;
   logic [CmpW-1:0]   take_cmp;
   logic [WideW-1:0]  req_pay_wide;
   logic [WideW-1:0]  rd_pay_wide;
   logic [CmpW-1:0]   occ_wide;
   entry_type         req_entry;
   logic [CntW-1:0]   pos_next;
   logic [CntW-1:0]   pos_prev;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   assign rd_addr = wrap_add(head_ff, rd_pos);
   assign wr_addr = wrap_add(head_ff, wr_pos);

   assign pos_next = pos_ff + CntW'(1);
   assign pos_prev = pos_ff - CntW'(1);

   // Effective capacity and batch length
   always_comb begin
      count_cmp  = CmpW'(count_ff);
      amount_cmp = CmpW'(req_amount);
      cap_eff    = CmpW'(cap_ff);
      if (cap_eff > CmpW'(QUEUE_DEPTH)) begin
         cap_eff = CmpW'(QUEUE_DEPTH);
      end
      take_cmp = (count_cmp < amount_cmp) ? count_cmp : amount_cmp;
      if (take_cmp > CmpW'(MaxResults)) begin
         take_cmp = CmpW'(MaxResults);
      end
   end

   // Payload width adaption between ports and storage
   assign req_pay_wide  = WideW'(req_record_payload);
   assign req_entry     = '{crit: req_record_critical, pay: req_pay_wide[PAYLOAD_BITS-1:0]};
   assign rd_pay_wide   = WideW'(rd_data_ff.pay);
   assign occ_wide      = CmpW'(count_ff);

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      take_in       = take_ff;
      new_entry_in  = new_entry_ff;
      res_kind_in   = res_kind_ff;
      res_status_in = res_status_ff;
      mem_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;
      rd_pos        = '0;
      wr_pos        = '0;
      mem_wr_data   = rd_data_ff;

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_kind_in    = rsp_kind_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_crit_in    = rsp_crit_ff;
      rsp_outv_in    = rsp_outv_ff;
      rsp_occ_in     = rsp_occ_ff;
      rsp_last_in    = rsp_last_ff;

      cap_in = cap_ff;
      if (csr_valid && csr_ready) begin
         cap_in = csr_capacity_limit;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_status_in = ST_ACCEPTED;
               state_in      = S_DONE;
               unique case (op_type'(req_opcode))
                  OP_ENQUEUE: begin
                     res_kind_in  = KIND_ENQ_STATUS;
                     new_entry_in = req_entry;
                     if (count_cmp < cap_eff) begin
                        mem_wr_en   = 1'b1;
                        wr_pos      = count_ff;
                        mem_wr_data = req_entry;
                        count_in    = count_ff + CntW'(1);
                     end else if (count_ff == '0) begin
                        res_status_in = ST_REJECTED;
                     end else begin
                        // full: look for the oldest droppable record
                        mem_rd_en = 1'b1;
                        rd_pos    = '0;
                        pos_in    = '0;
                        state_in  = S_SCAN;
                     end
                  end
                  OP_PEEK: begin
                     res_kind_in = KIND_PEEK;
                     take_in     = CntW'(take_cmp);
                     if (take_cmp != '0) begin
                        mem_rd_en = 1'b1;
                        rd_pos    = '0;
                        pos_in    = '0;
                        state_in  = S_PEEK;
                     end
                  end
                  OP_REMOVE: begin
                     res_kind_in = KIND_REMOVE_ACK;
                     if (amount_cmp != '0 && count_ff != '0) begin
                        if (amount_cmp >= count_cmp) begin
                           count_in = '0;
                        end else begin
                           head_in  = wrap_add(head_ff, CntW'(amount_cmp));
                           count_in = count_ff - CntW'(amount_cmp);
                        end
                     end
                  end
                  OP_COUNT: begin
                     res_kind_in = KIND_COUNT;
                  end
                  default: begin
                     res_kind_in = KIND_COUNT;
                  end
               endcase
            end
         end

         // one critical flag per cycle, oldest first
         S_SCAN: begin
            if (!rd_data_ff.crit) begin
               if (pos_ff == '0) begin
                  head_in  = wrap_add(head_ff, CntW'(1));
                  count_in = count_ff - CntW'(1);
                  state_in = S_APPEND;
               end else begin
                  mem_rd_en = 1'b1;
                  rd_pos    = pos_prev;
                  pos_in    = pos_prev;
                  state_in  = S_SHIFT;
               end
            end else if (pos_next == count_ff) begin
               res_status_in = ST_REJECTED;
               state_in      = S_DONE;
            end else begin
               mem_rd_en = 1'b1;
               rd_pos    = pos_next;
               pos_in    = pos_next;
            end
         end

         // move the records ahead of the gap up by one, newest of them first
         S_SHIFT: begin
            mem_wr_en   = 1'b1;
            wr_pos      = pos_next;
            mem_wr_data = rd_data_ff;
            if (pos_ff == '0) begin
               head_in  = wrap_add(head_ff, CntW'(1));
               count_in = count_ff - CntW'(1);
               state_in = S_APPEND;
            end else begin
               mem_rd_en = 1'b1;
               rd_pos    = pos_prev;
               pos_in    = pos_prev;
            end
         end

         // after the drop, the new record goes in only if it now fits
         S_APPEND: begin
            state_in = S_DONE;
            if (count_cmp >= cap_eff) begin
               res_status_in = ST_REJECTED;
            end else begin
               mem_wr_en     = 1'b1;
               wr_pos        = count_ff;
               mem_wr_data   = new_entry_ff;
               count_in      = count_ff + CntW'(1);
               res_status_in = ST_DROPPED;
            end
         end

         // one record per cycle into the output register while it is free
         S_PEEK: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = KIND_PEEK;
               rsp_status_in  = ST_ACCEPTED;
               rsp_payload_in = rd_pay_wide[PayW-1:0];
               rsp_crit_in    = rd_data_ff.crit;
               rsp_outv_in    = 1'b1;
               rsp_occ_in     = occ_wide[OccW-1:0];
               rsp_last_in    = (pos_next == take_ff);
               if (pos_next == take_ff) begin
                  state_in = S_IDLE;
               end else begin
                  mem_rd_en = 1'b1;
                  rd_pos    = pos_next;
                  pos_in    = pos_next;
               end
            end
         end

         // single-beat result
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = res_kind_ff;
               rsp_status_in  = res_status_ff;
               rsp_payload_in = '0;
               rsp_crit_in    = 1'b0;
               rsp_outv_in    = 1'b0;
               rsp_occ_in     = occ_wide[OccW-1:0];
               rsp_last_in    = 1'b1;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Memory: one write and one registered read per cycle, never the same entry
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         pos_ff       <= '0;
         take_ff      <= '0;
         cap_ff       <= CapReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         take_ff      <= take_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      new_entry_ff   <= new_entry_in;
      res_kind_ff    <= res_kind_in;
      res_status_ff  <= res_status_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_crit_ff    <= rsp_crit_in;
      rsp_outv_ff    <= rsp_outv_in;
      rsp_occ_ff     <= rsp_occ_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_enqueue_status = rsp_status_ff;
   assign rsp_out_payload    = rsp_payload_ff;
   assign rsp_out_critical   = rsp_crit_ff;
   assign rsp_out_valid      = rsp_outv_ff;
   assign rsp_occupancy      = rsp_occ_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

// ===== rtl/core/pdbq_checker.sv =====
// Port-level checks for the priority-drop batch queue, bound to the top level.
module pdbq_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [pdbq_pkg::KindW-1:0]   rsp_result_kind,
   input logic [pdbq_pkg::StatusW-1:0] rsp_enqueue_status,
   input logic [pdbq_pkg::PayW-1:0]    rsp_out_payload,
   input logic                         rsp_out_valid,
   input logic                         rsp_last
);
   import pdbq_pkg::*;

   // a stalled result beat stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result beat dropped while stalled");

   // a stalled result beat keeps its record and marker
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_out_payload) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // only peek beats carry a record
   a_record_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_valid |-> rsp_result_kind == KIND_PEEK)
      else $error("record carried by a non-peek beat");

   // every non-peek result is a single beat
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind != KIND_PEEK |-> rsp_last)
      else $error("non-peek result without last");

   // a status other than accepted appears only on enqueue beats
   a_status_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_enqueue_status != ST_ACCEPTED |->
         rsp_result_kind == KIND_ENQ_STATUS &&
         (rsp_enqueue_status == ST_DROPPED || rsp_enqueue_status == ST_REJECTED))
      else $error("bad enqueue status");

endmodule

bind priority_drop_batch_queue_core pdbq_checker u_pdbq_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_result_kind    (rsp_result_kind),
   .rsp_enqueue_status (rsp_enqueue_status),
   .rsp_out_payload    (rsp_out_payload),
   .rsp_out_valid      (rsp_out_valid),
   .rsp_last           (rsp_last)
);
